// ----- rtl/nvqpt_pkg.sv -----
// ----------------------------------------------------------------------------
// nvqpt_pkg: shared definitions for the NVMe queue pair tracker
// Sizes, result codes, register indexes and reset values of the config set.
// ----------------------------------------------------------------------------
package nvqpt_pkg;

    localparam int CID_SLOTS   = 32;
    localparam int QUEUE_PAIRS = 2;

    localparam int QID_W     = (QUEUE_PAIRS > 1) ? $clog2(QUEUE_PAIRS) : 1;
    localparam int CID_IDX_W = (CID_SLOTS > 1) ? $clog2(CID_SLOTS) : 1;
    localparam int TAG_DEPTH = QUEUE_PAIRS * CID_SLOTS;
    localparam int TAG_AW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;

    localparam int PTR_W    = 16;
    localparam int TAG_W    = 16;
    localparam int DW_W     = 32;
    localparam int MAXCID_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        OUT_OK          = 3'd0,
        OUT_NOT_READY   = 3'd1,
        OUT_BAD_SQID    = 3'd2,
        OUT_UNASSOC     = 3'd3,
        OUT_BAD_CID     = 3'd4,
        OUT_QUEUE_FULL  = 3'd5,
        OUT_NO_FREE_CID = 3'd6
    } outcome_t;

    typedef enum logic {
        OP_SUBMIT  = 1'b0,
        OP_CONSUME = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADMIN_SQ_LAST = 3'd0,
        REG_ADMIN_CQ_LAST = 3'd1,
        REG_IO_SQ_LAST    = 3'd2,
        REG_IO_CQ_LAST    = 3'd3,
        REG_MAX_CID       = 3'd4,
        REG_IO_QUEUES_ON  = 3'd5
    } reg_index_t;

    localparam logic [PTR_W-1:0]    RING_LAST_RESET = 16'd3;
    localparam logic [MAXCID_W-1:0] MAX_CID_RESET   = 5'd31;

endpackage

// ----- rtl/nvme_queue_pair_tracker.sv -----
// ----------------------------------------------------------------------------
// nvme_queue_pair_tracker: host-side NVMe SQ/CQ bookkeeping
// Tracks tail, head, completion position, phase and command IDs for the
// admin and one I/O queue pair; returns doorbell values and completion data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one queue event per transfer:
//   opcode 0 submits req_tag to submission queue queue_id, opcode 1 consumes
//   a completion entry (cqe_*) from completion queue queue_id.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   event: outcome, doorbell value, assigned command ID and completion data.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets ring
//   sizes, max_cid and io_queues_on; cfg_ready is always high. Write it only
//   while no event is in flight.
//   The input register captures the event and its owner tag read, and the
//   update logic loads the result register and the queue state from it, so
//   the next event sees the new state directly. Throughput is one event per
//   cycle while out_stall is low or no result is held.
//   When out_stall is high the result holds, the input register fills and
//   in_stall rises in the same cycle; it drops as soon as the result leaves.
//   Reset clears all pointers, frees every command ID, sets both phases to 1
//   and loads the config defaults. Owner tags are not cleared; there is no
//   init sweep, events are taken right after reset.
// ----------------------------------------------------------------------------
module nvme_queue_pair_tracker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic        queue_id,
    input  logic [15:0] req_tag,
    input  logic [15:0] cqe_status,
    input  logic [15:0] cqe_sqid,
    input  logic [15:0] cqe_cid,
    input  logic [15:0] cqe_sqhd,
    input  logic [31:0] cqe_dw0,
    input  logic [31:0] cqe_dw1,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  outcome,
    output logic [15:0] doorbell_value,
    output logic [4:0]  assigned_cid,
    output logic [15:0] done_tag,
    output logic [15:0] done_status,
    output logic [31:0] done_dw0,
    output logic [31:0] done_dw1
);

    localparam int QP  = nvqpt_pkg::QUEUE_PAIRS;
    localparam int NC  = nvqpt_pkg::CID_SLOTS;
    localparam int CW  = nvqpt_pkg::CID_IDX_W;
    localparam int AW  = nvqpt_pkg::TAG_AW;

    // configuration registers
    logic [15:0] admin_sq_last_reg, admin_cq_last_reg;
    logic [15:0] io_sq_last_reg, io_cq_last_reg;
    logic [4:0]  max_cid_reg;
    logic        io_queues_on_reg;

    // queue state
    logic [15:0] sq_tail_reg [QP];
    logic [15:0] sq_head_reg [QP];
    logic [15:0] cq_pos_reg  [QP];
    logic        cq_phase_reg [QP];
    logic [NC-1:0] cid_busy_reg [QP];

    logic [15:0] sq_tail_next [QP];
    logic [15:0] sq_head_next [QP];
    logic [15:0] cq_pos_next  [QP];
    logic        cq_phase_next [QP];
    logic [NC-1:0] cid_busy_next [QP];

    // owner tag memory
    logic [15:0] tag_mem [nvqpt_pkg::TAG_DEPTH];
    logic [15:0] tag_rd_reg;
    logic [AW-1:0] tag_rd_addr;
    logic        tag_wr_en;
    logic [AW-1:0] tag_wr_addr;

    // input register
    logic        in_valid_reg;
    logic        op_reg;
    logic        qid_reg;
    logic [15:0] req_tag_reg;
    logic [15:0] status_reg;
    logic [15:0] sqid_reg;
    logic [15:0] cid_reg;
    logic [15:0] sqhd_reg;
    logic [31:0] dw0_reg;
    logic [31:0] dw1_reg;

    // result register
    logic        out_valid_reg;
    nvqpt_pkg::outcome_t outcome_reg, outcome_next;
    logic [15:0] doorbell_reg, doorbell_next;
    logic [4:0]  acid_reg, acid_next;
    logic [15:0] done_tag_reg, done_tag_next;
    logic [15:0] done_status_reg, done_status_next;
    logic [31:0] done_dw0_reg, done_dw0_next;
    logic [31:0] done_dw1_reg, done_dw1_next;

    logic        advance;
    logic        in_xfer;

    // processing-stage decode
    logic [15:0]   sq_last, cq_last, tail_inc, pos;
    logic [NC-1:0] cand;
    logic          free_found;
    logic [CW-1:0] free_idx;
    logic [CW-1:0] cid_idx;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cid_idx   = cid_reg[CW-1:0];

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            admin_sq_last_reg <= nvqpt_pkg::RING_LAST_RESET;
            admin_cq_last_reg <= nvqpt_pkg::RING_LAST_RESET;
            io_sq_last_reg    <= nvqpt_pkg::RING_LAST_RESET;
            io_cq_last_reg    <= nvqpt_pkg::RING_LAST_RESET;
            max_cid_reg       <= nvqpt_pkg::MAX_CID_RESET;
            io_queues_on_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nvqpt_pkg::REG_ADMIN_SQ_LAST: admin_sq_last_reg <= cfg_data;
                nvqpt_pkg::REG_ADMIN_CQ_LAST: admin_cq_last_reg <= cfg_data;
                nvqpt_pkg::REG_IO_SQ_LAST:    io_sq_last_reg    <= cfg_data;
                nvqpt_pkg::REG_IO_CQ_LAST:    io_cq_last_reg    <= cfg_data;
                nvqpt_pkg::REG_MAX_CID:       max_cid_reg       <= cfg_data[4:0];
                nvqpt_pkg::REG_IO_QUEUES_ON:  io_queues_on_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg      <= opcode;
            qid_reg     <= queue_id;
            req_tag_reg <= req_tag;
            status_reg  <= cqe_status;
            sqid_reg    <= cqe_sqid;
            cid_reg     <= cqe_cid;
            sqhd_reg    <= cqe_sqhd;
            dw0_reg     <= cqe_dw0;
            dw1_reg     <= cqe_dw1;
        end
    end

    // owner tag memory; forward a same-cycle write to the read port
    assign tag_rd_addr = AW'(queue_id) * AW'(NC) + AW'(cqe_cid[CW-1:0]);
    assign tag_wr_addr = AW'(qid_reg) * AW'(NC) + AW'(free_idx);

    always_ff @(posedge clk)
    begin
        if (tag_wr_en)
        begin
            tag_mem[tag_wr_addr] <= req_tag_reg;
        end
        if (in_xfer)
        begin
            if (tag_wr_en && (tag_wr_addr == tag_rd_addr))
                tag_rd_reg <= req_tag_reg;
            else
                tag_rd_reg <= tag_mem[tag_rd_addr];
        end
    end

    // lowest free command ID within the limit
    always_comb
    begin
        cand       = '0;
        free_idx   = '0;
        for (int i = 0; i < NC; i++)
        begin
            cand[i] = !cid_busy_reg[qid_reg][i] && (i <= int'(max_cid_reg));
        end
        for (int i = NC - 1; i >= 0; i--)
        begin
            if (cand[i])
                free_idx = CW'(i);
        end
        free_found = |cand;
    end

    // update logic
    always_comb
    begin
        sq_last  = qid_reg ? io_sq_last_reg : admin_sq_last_reg;
        cq_last  = qid_reg ? io_cq_last_reg : admin_cq_last_reg;
        tail_inc = (sq_tail_reg[qid_reg] == sq_last) ? 16'd0 : sq_tail_reg[qid_reg] + 16'd1;
        pos      = cq_pos_reg[qid_reg];

        for (int q = 0; q < QP; q++)
        begin
            sq_tail_next[q]  = sq_tail_reg[q];
            sq_head_next[q]  = sq_head_reg[q];
            cq_pos_next[q]   = cq_pos_reg[q];
            cq_phase_next[q] = cq_phase_reg[q];
            cid_busy_next[q] = cid_busy_reg[q];
        end

        tag_wr_en        = 1'b0;
        outcome_next     = nvqpt_pkg::OUT_OK;
        doorbell_next    = '0;
        acid_next        = '0;
        done_tag_next    = '0;
        done_status_next = '0;
        done_dw0_next    = '0;
        done_dw1_next    = '0;

        if (op_reg == nvqpt_pkg::OP_SUBMIT)
        begin
            if (qid_reg && !io_queues_on_reg)
                outcome_next = nvqpt_pkg::OUT_BAD_SQID;
            else if (tail_inc == sq_head_reg[qid_reg])
                outcome_next = nvqpt_pkg::OUT_QUEUE_FULL;
            else if (!free_found)
                outcome_next = nvqpt_pkg::OUT_NO_FREE_CID;
            else
            begin
                tag_wr_en     = advance;
                doorbell_next = tail_inc;
                acid_next     = 5'(free_idx);
                sq_tail_next[qid_reg]            = tail_inc;
                cid_busy_next[qid_reg][free_idx] = 1'b1;
            end
        end
        else
        begin
            if (status_reg[0] != cq_phase_reg[qid_reg])
                outcome_next = nvqpt_pkg::OUT_NOT_READY;
            else if (sqid_reg > {15'd0, io_queues_on_reg})
                outcome_next = nvqpt_pkg::OUT_BAD_SQID;
            else if (sqid_reg != {15'd0, qid_reg})
                outcome_next = nvqpt_pkg::OUT_UNASSOC;
            else if ((cid_reg > {11'd0, max_cid_reg}) || (32'(cid_reg) >= 32'(NC)) ||
                     !cid_busy_reg[qid_reg][cid_idx])
                outcome_next = nvqpt_pkg::OUT_BAD_CID;
            else
            begin
                done_tag_next    = tag_rd_reg;
                done_status_next = status_reg | 16'd1;
                done_dw0_next    = dw0_reg;
                done_dw1_next    = dw1_reg;
                cid_busy_next[qid_reg][cid_idx] = 1'b0;
                sq_head_next[qid_reg] = sqhd_reg;
                // step the completion position; at or past the last index wrap it to zero and flip the expected phase
                if (pos < cq_last)
                    cq_pos_next[qid_reg] = pos + 16'd1;
                else
                begin
                    cq_pos_next[qid_reg]   = 16'd0;
                    cq_phase_next[qid_reg] = !cq_phase_reg[qid_reg];
                end
                doorbell_next = cq_pos_next[qid_reg];
            end
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < QP; q++)
            begin
                sq_tail_reg[q]  <= '0;
                sq_head_reg[q]  <= '0;
                cq_pos_reg[q]   <= '0;
                cq_phase_reg[q] <= 1'b1;
                cid_busy_reg[q] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                for (int q = 0; q < QP; q++)
                begin
                    sq_tail_reg[q]  <= sq_tail_next[q];
                    sq_head_reg[q]  <= sq_head_next[q];
                    cq_pos_reg[q]   <= cq_pos_next[q];
                    cq_phase_reg[q] <= cq_phase_next[q];
                    cid_busy_reg[q] <= cid_busy_next[q];
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            outcome_reg     <= outcome_next;
            doorbell_reg    <= doorbell_next;
            acid_reg        <= acid_next;
            done_tag_reg    <= done_tag_next;
            done_status_reg <= done_status_next;
            done_dw0_reg    <= done_dw0_next;
            done_dw1_reg    <= done_dw1_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign doorbell_value = doorbell_reg;
    assign assigned_cid   = acid_reg;
    assign done_tag       = done_tag_reg;
    assign done_status    = done_status_reg;
    assign done_dw0       = done_dw0_reg;
    assign done_dw1       = done_dw1_reg;

    // a held result must block the update stage
    a_hold_blocks_update: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !advance)
        else $error("update stage advanced over a stalled result");

    // a granted command ID is busy afterwards
    a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == nvqpt_pkg::OP_SUBMIT) &&
         (outcome_next == nvqpt_pkg::OUT_OK))
        |=> cid_busy_reg[$past(qid_reg)][$past(free_idx)])
        else $error("granted command ID not marked busy");

    // a failed event leaves the ring pointers alone
    a_fail_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (outcome_next != nvqpt_pkg::OUT_OK))
        |=> ($stable(sq_tail_reg[0]) && $stable(sq_tail_reg[1]) &&
             $stable(cq_pos_reg[0]) && $stable(cq_pos_reg[1])))
        else $error("failed event changed queue pointers");

    // a tag write happens only on a granted submit
    a_tag_write_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        tag_wr_en |-> (advance && (outcome_next == nvqpt_pkg::OUT_OK) &&
                       (op_reg == nvqpt_pkg::OP_SUBMIT)))
        else $error("owner tag written outside a granted submit");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for nvme_queue_pair_tracker
// Drives submit and completion events through the stall handshake, mirrors
// the ring, phase and command ID bookkeeping in a scoreboard and compares
// every returned result field by field, across several register settings and
// random idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int MODE_RUN        = 38;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        nvqpt_pkg::opcode_t op;
        logic               qid;
        logic [15:0]        req_tag;
        logic [15:0]        cqe_status;
        logic [15:0]        cqe_sqid;
        logic [15:0]        cqe_cid;
        logic [15:0]        cqe_sqhd;
        logic [31:0]        cqe_dw0;
        logic [31:0]        cqe_dw1;
    } queue_event_t;

    typedef struct packed {
        nvqpt_pkg::outcome_t code;
        logic [15:0]         doorbell;
        logic [4:0]          cid;
        logic [15:0]         tag;
        logic [15:0]         status;
        logic [31:0]         dw0;
        logic [31:0]         dw1;
    } tracker_result_t;

    class tracker_scoreboard;
        logic [15:0]                     sq_last[nvqpt_pkg::QUEUE_PAIRS];
        logic [15:0]                     cq_last[nvqpt_pkg::QUEUE_PAIRS];
        logic [nvqpt_pkg::MAXCID_W-1:0]  cid_max;
        logic                            io_on;
        logic [15:0]                     sq_tail[nvqpt_pkg::QUEUE_PAIRS];
        logic [15:0]                     sq_head[nvqpt_pkg::QUEUE_PAIRS];
        logic [15:0]                     cq_pos[nvqpt_pkg::QUEUE_PAIRS];
        logic                            cq_phase[nvqpt_pkg::QUEUE_PAIRS];
        logic [nvqpt_pkg::CID_SLOTS-1:0] busy[nvqpt_pkg::QUEUE_PAIRS];
        logic [nvqpt_pkg::TAG_W-1:0]
            owner[nvqpt_pkg::QUEUE_PAIRS][nvqpt_pkg::CID_SLOTS];
        tracker_result_t                 pending_results[$];
        int                              mismatches;

        function new();
            for (int q = 0; q < nvqpt_pkg::QUEUE_PAIRS; q++)
            begin
                sq_last[q]  = nvqpt_pkg::RING_LAST_RESET;
                cq_last[q]  = nvqpt_pkg::RING_LAST_RESET;
                sq_tail[q]  = '0;
                sq_head[q]  = '0;
                cq_pos[q]   = '0;
                cq_phase[q] = 1'b1;
                busy[q]     = '0;
            end
            cid_max    = nvqpt_pkg::MAX_CID_RESET;
            io_on      = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(nvqpt_pkg::reg_index_t idx, logic [15:0] data);
            case (idx)
                nvqpt_pkg::REG_ADMIN_SQ_LAST: sq_last[0] = data;
                nvqpt_pkg::REG_ADMIN_CQ_LAST: cq_last[0] = data;
                nvqpt_pkg::REG_IO_SQ_LAST:    sq_last[1] = data;
                nvqpt_pkg::REG_IO_CQ_LAST:    cq_last[1] = data;
                nvqpt_pkg::REG_MAX_CID:       cid_max = data[nvqpt_pkg::MAXCID_W-1:0];
                nvqpt_pkg::REG_IO_QUEUES_ON:  io_on = data[0];
                default: ;
            endcase
        endfunction

        // Apply one event to the mirrored state; failures leave it untouched.
        function tracker_result_t track_event(queue_event_t ev);
            tracker_result_t                 res;
            logic [15:0]                     nxt;
            logic [nvqpt_pkg::CID_IDX_W-1:0] cidx;
            int                              q;
            int                              free_id;
            res  = '0;
            q    = int'(ev.qid);
            cidx = ev.cqe_cid[nvqpt_pkg::CID_IDX_W-1:0];
            if (ev.op == nvqpt_pkg::OP_SUBMIT)
            begin
                nxt = (sq_tail[q] == sq_last[q]) ? 16'd0 : sq_tail[q] + 16'd1;
                if (q != 0 && !io_on)
                    res.code = nvqpt_pkg::OUT_BAD_SQID;
                else if (nxt == sq_head[q])
                    res.code = nvqpt_pkg::OUT_QUEUE_FULL;
                else
                begin
                    free_id = -1;
                    for (int i = 0; i < nvqpt_pkg::CID_SLOTS; i++)
                        if (free_id < 0 && i <= cid_max && !busy[q][i])
                            free_id = i;
                    if (free_id < 0)
                        res.code = nvqpt_pkg::OUT_NO_FREE_CID;
                    else
                    begin
                        busy[q][free_id]  = 1'b1;
                        owner[q][free_id] = ev.req_tag;
                        sq_tail[q]        = nxt;
                        res.code          = nvqpt_pkg::OUT_OK;
                        res.doorbell      = nxt;
                        res.cid           = free_id[nvqpt_pkg::CID_IDX_W-1:0];
                    end
                end
            end
            else
            begin
                if (ev.cqe_status[0] != cq_phase[q])
                    res.code = nvqpt_pkg::OUT_NOT_READY;
                else if (ev.cqe_sqid > {15'd0, io_on})
                    res.code = nvqpt_pkg::OUT_BAD_SQID;
                else if (ev.cqe_sqid != 16'(q))
                    res.code = nvqpt_pkg::OUT_UNASSOC;
                else if (ev.cqe_cid > cid_max || ev.cqe_cid >= nvqpt_pkg::CID_SLOTS ||
                         !busy[q][cidx])
                    res.code = nvqpt_pkg::OUT_BAD_CID;
                else
                begin
                    res.code   = nvqpt_pkg::OUT_OK;
                    res.tag    = owner[q][cidx];
                    res.status = ev.cqe_status | 16'd1;
                    res.dw0    = ev.cqe_dw0;
                    res.dw1    = ev.cqe_dw1;
                    busy[q][cidx] = 1'b0;
                    sq_head[q]    = ev.cqe_sqhd;
                    // wrap at or past the last index and flip the phase
                    if (cq_pos[q] < cq_last[q])
                        cq_pos[q] = cq_pos[q] + 16'd1;
                    else
                    begin
                        cq_pos[q]   = '0;
                        cq_phase[q] = ~cq_phase[q];
                    end
                    res.doorbell = cq_pos[q];
                end
            end
            return res;
        endfunction

        function void note_event(queue_event_t ev);
            pending_results.push_back(track_event(ev));
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(tracker_result_t got);
            tracker_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with no event waiting, outcome %0d", got.code));
                return;
            end
            want = pending_results.pop_front();
            if (got.code !== want.code)
                report($sformatf("outcome %0d, want %0d", got.code, want.code));
            if (got.doorbell !== want.doorbell)
                report($sformatf("doorbell_value %h, want %h", got.doorbell, want.doorbell));
            if (got.cid !== want.cid)
                report($sformatf("assigned_cid %0d, want %0d", got.cid, want.cid));
            if (got.tag !== want.tag)
                report($sformatf("done_tag %h, want %h", got.tag, want.tag));
            if (got.status !== want.status)
                report($sformatf("done_status %h, want %h", got.status, want.status));
            if (got.dw0 !== want.dw0)
                report($sformatf("done_dw0 %h, want %h", got.dw0, want.dw0));
            if (got.dw1 !== want.dw1)
                report($sformatf("done_dw1 %h, want %h", got.dw1, want.dw1));
        endtask
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index  = '0;
    logic [15:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        opcode     = 1'b0;
    logic        queue_id   = 1'b0;
    logic [15:0] req_tag    = '0;
    logic [15:0] cqe_status = '0;
    logic [15:0] cqe_sqid   = '0;
    logic [15:0] cqe_cid    = '0;
    logic [15:0] cqe_sqhd   = '0;
    logic [31:0] cqe_dw0    = '0;
    logic [31:0] cqe_dw1    = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  outcome;
    logic [15:0] doorbell_value;
    logic [4:0]  assigned_cid;
    logic [15:0] done_tag;
    logic [15:0] done_status;
    logic [31:0] done_dw0;
    logic [31:0] done_dw1;

    tracker_result_t   seen;
    tracker_scoreboard sb = new();
    int                send_pct    = 0;
    int                stall_pct   = 0;
    int                cycle_count = 0;
    int                mode_turn   = 0;

    assign seen = tracker_result_t'({outcome, doorbell_value, assigned_cid, done_tag,
                                     done_status, done_dw0, done_dw1});

    nvme_queue_pair_tracker u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .queue_id       (queue_id),
        .req_tag        (req_tag),
        .cqe_status     (cqe_status),
        .cqe_sqid       (cqe_sqid),
        .cqe_cid        (cqe_cid),
        .cqe_sqhd       (cqe_sqhd),
        .cqe_dw0        (cqe_dw0),
        .cqe_dw1        (cqe_dw1),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .outcome        (outcome),
        .doorbell_value (doorbell_value),
        .assigned_cid   (assigned_cid),
        .done_tag       (done_tag),
        .done_status    (done_status),
        .done_dw0       (done_dw0),
        .done_dw1       (done_dw1)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(seen);
    end

    task automatic set_idle_mode(idle_mode_t m);
        case (m)
            IDLE_SENDER:   begin send_pct <= 45; stall_pct <= 0;  end
            IDLE_RECEIVER: begin send_pct <= 0;  stall_pct <= 45; end
            IDLE_BOTH:     begin send_pct <= 20; stall_pct <= 20; end
            default:       begin send_pct <= 0;  stall_pct <= 0;  end
        endcase
    endtask

    // Present one event, hold it until the transfer, then maybe go idle.
    task automatic drive_event(queue_event_t ev);
        in_valid   <= 1'b1;
        opcode     <= ev.op;
        queue_id   <= ev.qid;
        req_tag    <= ev.req_tag;
        cqe_status <= ev.cqe_status;
        cqe_sqid   <= ev.cqe_sqid;
        cqe_cid    <= ev.cqe_cid;
        cqe_sqhd   <= ev.cqe_sqhd;
        cqe_dw0    <= ev.cqe_dw0;
        cqe_dw1    <= ev.cqe_dw1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_event(ev);
        if (send_pct > 0 && $urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] a_sq, a_cq, i_sq, i_cq, mc, on);
        nvqpt_pkg::reg_index_t regs[6];
        logic [15:0]           vals[6];
        regs = '{nvqpt_pkg::REG_ADMIN_SQ_LAST, nvqpt_pkg::REG_ADMIN_CQ_LAST,
                 nvqpt_pkg::REG_IO_SQ_LAST, nvqpt_pkg::REG_IO_CQ_LAST,
                 nvqpt_pkg::REG_MAX_CID, nvqpt_pkg::REG_IO_QUEUES_ON};
        vals = '{a_sq, a_cq, i_sq, i_cq, mc, on};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic queue_event_t compose_event(nvqpt_pkg::opcode_t op, logic qid,
                                                   logic [15:0] tag, status, sqid, cid, sqhd,
                                                   logic [31:0] dw0, dw1);
        queue_event_t ev;
        ev = '{op, qid, tag, status, sqid, cid, sqhd, dw0, dw1};
        return ev;
    endfunction

    // Mostly submits and completions that match the mirrored state, the rest
    // completions whose phase, SQ ID and command ID are each set at random, so any check may trip.
    function automatic queue_event_t random_event();
        queue_event_t ev;
        int           pick;
        int           q;
        int           start;
        int           cid_pick;
        ev.op         = nvqpt_pkg::OP_SUBMIT;
        ev.qid        = 1'($urandom);
        ev.req_tag    = 16'($urandom);
        ev.cqe_status = 16'($urandom);
        ev.cqe_sqid   = 16'($urandom);
        ev.cqe_cid    = 16'($urandom);
        ev.cqe_sqhd   = 16'($urandom);
        ev.cqe_dw0    = $urandom;
        ev.cqe_dw1    = $urandom;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            if (!sb.io_on && $urandom_range(9) != 0)
                ev.qid = 1'b0;
        end
        else if (pick < 88 && (sb.busy[0] != '0 || sb.busy[1] != '0))
        begin
            q = (sb.busy[0] == '0) ? 1 : (sb.busy[1] == '0) ? 0 : $urandom_range(1);
            start    = $urandom_range(nvqpt_pkg::CID_SLOTS - 1);
            cid_pick = start;
            for (int i = 0; i < nvqpt_pkg::CID_SLOTS; i++)
                if (sb.busy[q][(start + i) % nvqpt_pkg::CID_SLOTS])
                    cid_pick = (start + i) % nvqpt_pkg::CID_SLOTS;
            ev.op            = nvqpt_pkg::OP_CONSUME;
            ev.qid           = q[0];
            ev.cqe_status[0] = sb.cq_phase[q];
            ev.cqe_sqid      = 16'(q);
            ev.cqe_cid       = 16'(cid_pick);
            pick = $urandom_range(9);
            if (pick < 7)
                ev.cqe_sqhd = sb.sq_tail[q];
            else if (pick < 9)
                ev.cqe_sqhd = 16'($urandom_range(sb.sq_last[q]));
        end
        else
        begin
            ev.op = nvqpt_pkg::OP_CONSUME;
            q     = int'(ev.qid);
            if ($urandom_range(1))
                ev.cqe_status[0] = sb.cq_phase[q];
            if ($urandom_range(1))
                ev.cqe_sqid = 16'($urandom_range(2));
            if ($urandom_range(1))
                ev.cqe_cid = 16'($urandom_range(nvqpt_pkg::CID_SLOTS + 1));
        end
        return ev;
    endfunction

    task automatic run_random_phase();
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            if (n % MODE_RUN == 0)
            begin
                set_idle_mode(idle_mode_t'(mode_turn % 4));
                mode_turn++;
            end
            drive_event(random_event());
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: rings of four, I/O pair absent.
        drive_event(compose_event(nvqpt_pkg::OP_SUBMIT, 1'b0, 16'hFFFF, '0, '0, '0, '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_SUBMIT, 1'b0, 16'h0000, '0, '0, '0, '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_SUBMIT, 1'b0, 16'hA5A5, '0, '0, '0, '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_SUBMIT, 1'b0, 16'h1234, '0, '0, '0, '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_SUBMIT, 1'b1, 16'h5678, '0, '0, '0, '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'hFFFE, 16'h0000, 16'h0001,
                                  '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h0001, 16'h0001, 16'h0001,
                                  '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h0001, 16'hFFFF, 16'h0001,
                                  '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h0001, 16'h0000, 16'hFFFF,
                                  '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h0001, 16'h0000, 16'h0005,
                                  '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'hFFFF, 16'h0000, 16'h0001,
                                  16'h0003, 32'hFFFF_FFFF, 32'h0000_0000));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b1, '0, 16'h0001, 16'h0000, 16'h0000,
                                  '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h0001, 16'h0000, 16'h0000,
                                  16'h0000, 32'h0000_0000, 32'hFFFF_FFFF));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h8000, 16'h0000, 16'h0002,
                                  16'hFFFF, 32'h8000_0001, 32'h7FFF_FFFE));
        drive_event(compose_event(nvqpt_pkg::OP_SUBMIT, 1'b0, 16'h8001, '0, '0, '0, '0, '0, '0));
        // completion for command ID 0, which is already free, is refused as a bad command ID
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h0001, 16'h0000, 16'h0000,
                                  16'h0000, 32'h1357_9BDF, 32'h2468_ACE0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h8001, 16'h0000, 16'h0000,
                                  '0, '0, '0));
        drive_event(compose_event(nvqpt_pkg::OP_CONSUME, 1'b0, '0, 16'h0000, 16'h0000, 16'h001F,
                                  '0, '0, '0));
        wait_idle();

        apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd31, 16'd1);
        run_random_phase();
        apply_setting(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd31, 16'd1);
        run_random_phase();
        // shrink the rings below the current pointers
        apply_setting(16'd2, 16'd1, 16'd1, 16'd3, 16'd0, 16'd1);
        run_random_phase();
        apply_setting(16'd7, 16'd3, 16'd15, 16'd4, 16'd2, 16'd0);
        run_random_phase();
        apply_setting(16'd3, 16'd3, 16'd3, 16'd3, 16'd31, 16'd1);
        run_random_phase();
        apply_setting(16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)),
                      16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)),
                      16'($urandom_range(31)), 16'd1);
        run_random_phase();

        set_idle_mode(IDLE_NONE);
        repeat (8) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.pending_results.size()));
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/nvqpt_pkg.sv
rtl/nvme_queue_pair_tracker.sv
verif/tb_top.sv
